/* design/cct_pkg.sv */
package cct_pkg;

    localparam logic [3:0] EV_BASELINE   = 4'd0;
    localparam logic [3:0] EV_ADVANCE    = 4'd1;
    localparam logic [3:0] EV_WRAP       = 4'd2;
    localparam logic [3:0] EV_RESET      = 4'd3;
    localparam logic [3:0] EV_UNPROVEN   = 4'd4;
    localparam logic [3:0] EV_WIDTH_CHG  = 4'd5;
    localparam logic [3:0] EV_SRC_EPOCH  = 4'd6;
    localparam logic [3:0] EV_LINK_EPOCH = 4'd7;
    localparam logic [3:0] EV_RANGE      = 4'd8;
    localparam logic [3:0] EV_SEQ_REGR   = 4'd9;

    localparam logic [1:0] WIDTH_NONE = 2'd0;
    localparam logic [1:0] WIDTH_32   = 2'd1;
    localparam logic [1:0] WIDTH_BAD  = 2'd3;

    localparam logic [1:0] REG_WRAP_EN  = 2'd0;
    localparam logic [1:0] REG_CEILING  = 2'd1;
    localparam logic [1:0] REG_FLOOR    = 2'd2;
    localparam logic [1:0] REG_MAX_GAP  = 2'd3;

    localparam logic [62:0] ELAPSED_MAX = {63{1'b1}};
    localparam logic [64:0] SPAN32      = 65'h1_0000_0000;

    // one reading as passed from the front part to the back part
    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  width;
        logic        reset_flag;
        logic [63:0] stamp;
        logic [63:0] seq;
        logic [31:0] src;
        logic [31:0] link;
    } t_item;

    // result fields
    typedef struct packed {
        logic [3:0]  event_code;
        logic        ok;
        logic [63:0] delta;
        logic [62:0] elapsed;
        logic        gap;
        logic        wrapped;
        logic        usable;
        logic [63:0] missing;
        logic [31:0] gap_total;
    } t_result;

    // floor(m * f / 65536) saturated, m is 2^32 (w32) or 2^64-1
    function automatic logic [63:0] threshold(input logic w32, input logic [16:0] f);
        logic [81:0] prod;
        begin
            prod = 82'd0;
            if (w32) begin
                // 2^32 * f / 2^16 is f shifted up by 16, always fits
                threshold = {31'd0, f, 16'd0};
            end else begin
                // (2^64-1)*f >> 16 = (f<<48) - ceil(f/65536) ... computed exactly
                prod = ({1'b0, f, 64'd0} - {65'd0, f}) >> 16;
                threshold = (prod[81:64] != 18'd0) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                   : prod[63:0];
            end
        end
    endfunction

endpackage

/* design/cct_front.sv */
module cct_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  cct_pkg::t_item  i_item,
    input  logic            i_wen,
    input  logic [1:0]      i_windex,
    input  logic [62:0]     i_wdata,
    output logic            o_valid,
    input  logic            i_take,
    output cct_pkg::t_item  o_item,
    output logic [63:0]     o_ceil32,
    output logic [63:0]     o_ceil64,
    output logic [63:0]     o_floor32,
    output logic [63:0]     o_floor64,
    output logic            o_wrap_en,
    output logic [62:0]     o_max_gap
);

    logic [1:0]      r_cnt;
    logic            r_rd;
    logic            r_wr;
    cct_pkg::t_item  r_q [2];
    logic            w_push;
    logic            w_pop;

    logic [16:0]     r_ceil_f;
    logic [16:0]     r_floor_f;

    // two-entry queue to the back part
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= i_item;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_wrap_en <= 1'b1;
            r_ceil_f  <= 17'd58982;
            r_floor_f <= 17'd6554;
            o_max_gap <= 63'd60000000000;
        end else if (i_wen) begin
            unique case (i_windex)
                cct_pkg::REG_WRAP_EN: o_wrap_en <= i_wdata[0];
                cct_pkg::REG_CEILING: r_ceil_f  <= i_wdata[16:0];
                cct_pkg::REG_FLOOR:   r_floor_f <= i_wdata[16:0];
                cct_pkg::REG_MAX_GAP: o_max_gap <= i_wdata;
                default: ;
            endcase
        end
    end

    // thresholds, registered behind config writes
    always_ff @(posedge i_clk) begin
        o_ceil32  <= cct_pkg::threshold(1'b1, r_ceil_f);
        o_ceil64  <= cct_pkg::threshold(1'b0, r_ceil_f);
        o_floor32 <= cct_pkg::threshold(1'b1, r_floor_f);
        o_floor64 <= cct_pkg::threshold(1'b0, r_floor_f);
    end

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !w_pop) |=> o_full) else $error("full dropped without pop");
    a_empty_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && !w_push) |=> !o_valid) else $error("item appeared");
`endif

endmodule

/* design/cct_back.sv */
module cct_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_take,
    input  cct_pkg::t_item  i_item,
    input  logic [63:0]     i_ceil32,
    input  logic [63:0]     i_ceil64,
    input  logic [63:0]     i_floor32,
    input  logic [63:0]     i_floor64,
    input  logic            i_wrap_en,
    input  logic [62:0]     i_max_gap,
    output logic            o_empty,
    input  logic            i_pop,
    output cct_pkg::t_result o_res
);

    logic            r_bvalid;
    logic            r_ivalid;
    cct_pkg::t_item  r_base;
    logic [63:0]     r_missing;
    logic [31:0]     r_gaps;
    logic            r_full;
    cct_pkg::t_result r_res;

    cct_pkg::t_result w_res;
    logic            w_take_base;
    logic            w_drop_base;
    logic [63:0]     w_missing;
    logic [31:0]     w_gaps;
    logic [63:0]     w_diff;
    logic [63:0]     w_dseq;
    logic [62:0]     w_elapsed;
    logic            w_gap;
    logic [63:0]     w_ceil;
    logic [63:0]     w_floor;
    logic            w_proven;
    logic            w_w32;

    assign o_take  = i_valid && (!r_full || i_pop);
    assign o_empty = !r_full;
    assign o_res   = r_res;

    assign w_w32   = (i_item.width == cct_pkg::WIDTH_32);
    assign w_diff  = i_item.stamp - r_base.stamp;
    assign w_dseq  = i_item.seq - r_base.seq;
    assign w_ceil  = w_w32 ? i_ceil32 : i_ceil64;
    assign w_floor = w_w32 ? i_floor32 : i_floor64;
    assign w_proven = i_wrap_en && (i_item.width != cct_pkg::WIDTH_NONE)
                      && (r_base.value >= w_ceil) && (i_item.value <= w_floor);

    // elapsed time with overflow saturation, negative differences clamped to zero, and gap test
    always_comb begin
        if ((i_item.stamp[63] != r_base.stamp[63]) && (w_diff[63] != i_item.stamp[63]))
            w_elapsed = cct_pkg::ELAPSED_MAX;
        else if (w_diff[63])
            w_elapsed = 63'd0;
        else
            w_elapsed = w_diff[62:0];
        w_gap = (w_elapsed > i_max_gap) || (w_elapsed == 63'd0);
    end

    // classification
    always_comb begin
        w_res       = '0;
        w_res.ok    = 1'b1;
        w_take_base = 1'b0;
        w_drop_base = 1'b0;
        w_missing   = r_missing;
        w_gaps      = r_gaps;
        priority if (r_ivalid && i_item.src != r_base.src) begin
            w_take_base = 1'b1;
            w_res.event_code = cct_pkg::EV_SRC_EPOCH;
        end else if (r_ivalid && i_item.link != r_base.link) begin
            w_take_base = 1'b1;
            w_res.event_code = cct_pkg::EV_LINK_EPOCH;
        end else if (i_item.width == cct_pkg::WIDTH_BAD
                     || (w_w32 && i_item.value[63:32] != 32'd0)) begin
            w_drop_base = 1'b1;
            w_res.event_code = cct_pkg::EV_RANGE;
            w_res.ok = 1'b0;
        end else if (r_bvalid && i_item.width != r_base.width) begin
            w_take_base = 1'b1;
            w_res.event_code = cct_pkg::EV_WIDTH_CHG;
        end else if (r_bvalid && i_item.seq < r_base.seq) begin
            w_res.event_code = cct_pkg::EV_SEQ_REGR;
        end else if (i_item.reset_flag) begin
            w_take_base = 1'b1;
            w_res.event_code = cct_pkg::EV_RESET;
        end else if (!r_bvalid) begin
            w_take_base = 1'b1;
            w_res.event_code = cct_pkg::EV_BASELINE;
        end else begin
            w_take_base = 1'b1;
            if (w_dseq > 64'd1) w_missing = r_missing + w_dseq - 64'd1;
            if (i_item.value >= r_base.value || w_proven) begin
                w_res.elapsed = w_elapsed;
                w_res.gap     = w_gap;
                w_res.usable  = !w_gap;
                if (w_gap && r_gaps != 32'hFFFF_FFFF) w_gaps = r_gaps + 32'd1;
                if (i_item.value >= r_base.value) begin
                    w_res.event_code = cct_pkg::EV_ADVANCE;
                    w_res.delta = i_item.value - r_base.value;
                end else begin
                    w_res.event_code = cct_pkg::EV_WRAP;
                    w_res.wrapped = 1'b1;
                    w_res.delta = w_w32 ? (cct_pkg::SPAN32[63:0] - r_base.value
                                           + i_item.value)
                                        : (i_item.value - r_base.value);
                end
            end else begin
                w_res.event_code = cct_pkg::EV_UNPROVEN;
                w_res.ok = 1'b0;
            end
        end
        w_res.missing   = w_missing;
        w_res.gap_total = w_gaps;
    end

    // baseline state and running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvalid  <= 1'b0;
            r_ivalid  <= 1'b0;
            r_base    <= '0;
            r_missing <= 64'd0;
            r_gaps    <= 32'd0;
        end else if (o_take) begin
            r_missing <= w_missing;
            r_gaps    <= w_gaps;
            if (w_drop_base) r_bvalid <= 1'b0;
            if (w_take_base) begin
                r_bvalid <= 1'b1;
                r_ivalid <= 1'b1;
                r_base   <= i_item;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (o_take) begin
            r_full <= 1'b1;
        end else if (i_pop) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) r_res <= w_res;
    end

`ifndef SYNTHESIS
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (!r_res.ok == (r_res.event_code == cct_pkg::EV_RANGE
                                  || r_res.event_code == cct_pkg::EV_UNPROVEN)))
        else $error("continuity flag mismatch");
    a_gaps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gaps >= $past(r_gaps)) else $error("gap total decreased");
    a_iv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bvalid |-> r_ivalid) else $error("baseline without identity");
`endif

endmodule

/* design/counter_continuity_tracker_top.sv */
// Counter continuity tracker: takes one counter reading per transaction and
// returns one classified result per reading, in order. A reading is accepted
// every clock while the input queue is not full; it waits in the two-entry
// queue, and its result is registered when the back part takes it. Throughput
// is one reading per cycle while results are popped, set by the combinational
// 64-bit compare and subtract path there. Configuration writes are to be made
// by the user while no reading is in flight; the block itself does not enforce
// it. Ceiling and floor writes also pass through the threshold registers.
module counter_continuity_tracker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] i_reading_value,
    input  logic [1:0]  i_width_code,
    input  logic        i_reset_flag,
    input  logic signed [63:0] i_stamp_nanos,
    input  logic [63:0] i_seq_number,
    input  logic [31:0] i_source_epoch,
    input  logic [31:0] i_link_epoch,
    input  logic        i_cfg_wen,
    input  logic [1:0]  i_cfg_index,
    input  logic [62:0] i_cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_event_code,
    output logic        o_continuity_ok,
    output logic [63:0] o_value_delta,
    output logic [62:0] o_elapsed_time,
    output logic        o_gap_flag,
    output logic        o_wrap_flag,
    output logic        o_rate_usable,
    output logic [63:0] o_missing_total,
    output logic [31:0] o_gap_total
);

    cct_pkg::t_item   w_in;
    cct_pkg::t_item   w_q;
    cct_pkg::t_result w_res;
    logic             w_valid;
    logic             w_take;
    logic [63:0]      w_c32, w_c64, w_f32, w_f64;
    logic             w_wen;
    logic [62:0]      w_maxgap;

    assign w_in = '{value: i_reading_value, width: i_width_code,
                    reset_flag: i_reset_flag, stamp: i_stamp_nanos,
                    seq: i_seq_number, src: i_source_epoch, link: i_link_epoch};

    cct_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(w_in), .i_wen(i_cfg_wen), .i_windex(i_cfg_index),
        .i_wdata(i_cfg_data), .o_valid(w_valid), .i_take(w_take), .o_item(w_q),
        .o_ceil32(w_c32), .o_ceil64(w_c64), .o_floor32(w_f32),
        .o_floor64(w_f64), .o_wrap_en(w_wen), .o_max_gap(w_maxgap)
    );

    cct_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .o_take(w_take),
        .i_item(w_q), .i_ceil32(w_c32), .i_ceil64(w_c64), .i_floor32(w_f32),
        .i_floor64(w_f64), .i_wrap_en(w_wen), .i_max_gap(w_maxgap),
        .o_empty(empty), .i_pop(pop), .o_res(w_res)
    );

    assign o_event_code    = w_res.event_code;
    assign o_continuity_ok = w_res.ok;
    assign o_value_delta   = w_res.delta;
    assign o_elapsed_time  = w_res.elapsed;
    assign o_gap_flag      = w_res.gap;
    assign o_wrap_flag     = w_res.wrapped;
    assign o_rate_usable   = w_res.usable;
    assign o_missing_total = w_res.missing;
    assign o_gap_total     = w_res.gap_total;

endmodule

/* tb/tb.sv */
module tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [63:0] i_reading_value;
    logic [1:0]  i_width_code;
    logic        i_reset_flag;
    logic signed [63:0] i_stamp_nanos;
    logic [63:0] i_seq_number;
    logic [31:0] i_source_epoch;
    logic [31:0] i_link_epoch;
    logic        i_cfg_wen;
    logic [1:0]  i_cfg_index;
    logic [62:0] i_cfg_data;
    logic        empty;
    logic        pop;
    logic [3:0]  o_event_code;
    logic        o_continuity_ok;
    logic [63:0] o_value_delta;
    logic [62:0] o_elapsed_time;
    logic        o_gap_flag;
    logic        o_wrap_flag;
    logic        o_rate_usable;
    logic [63:0] o_missing_total;
    logic [31:0] o_gap_total;

    localparam logic [1:0] WIDTH_64 = 2'd2;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned N_RANDOM = 1000;

    counter_continuity_tracker_top dut (.*);

    // predictor copy of configuration and tracker state
    logic        mdl_wrap_en;
    logic [16:0] mdl_ceil_frac;
    logic [16:0] mdl_floor_frac;
    logic [62:0] mdl_max_gap;
    logic        mdl_base_ok;
    logic        mdl_id_ok;
    logic [63:0] mdl_value;
    logic [1:0]  mdl_width;
    logic [63:0] mdl_seq;
    logic [63:0] mdl_stamp;
    logic [31:0] mdl_src;
    logic [31:0] mdl_link;
    logic [63:0] mdl_missing;
    logic [31:0] mdl_gaps;

    cct_pkg::t_result expected_results[$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned n_pushed = 0;
    int unsigned n_checked = 0;
    int unsigned n_wraps = 0;
    bit quiet = 0;

    // directed table row: reading plus optional typed-in event
    typedef struct {
        cct_pkg::t_item rd;
        bit             has_ev;
        logic [3:0]     ev;
    } t_row;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[counter_continuity_tracker_top] ERROR");
            $finish;
        end
    end

    // floor(m * f / 65536) with saturation, 32-bit or full-width modulus
    function automatic logic [63:0] wrap_bound(logic [1:0] w, logic [16:0] f);
        logic [127:0] m;
        logic [127:0] p;
        m = (w == cct_pkg::WIDTH_32) ? 128'h1_0000_0000 : 128'hFFFF_FFFF_FFFF_FFFF;
        p = (m * f) >> 16;
        return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
    endfunction

    function automatic void latch_baseline(cct_pkg::t_item r);
        mdl_base_ok = 1;
        mdl_id_ok = 1;
        mdl_value = r.value;
        mdl_width = r.width;
        mdl_seq = r.seq;
        mdl_stamp = r.stamp;
        mdl_src = r.src;
        mdl_link = r.link;
    endfunction

    function automatic cct_pkg::t_result classify_reading(cct_pkg::t_item r);
        cct_pkg::t_result res;
        logic [63:0] diff;
        logic [63:0] el;
        logic gap;
        logic proven;
        res = '0;
        res.ok = 1;
        if (mdl_id_ok && r.src != mdl_src) begin
            latch_baseline(r);
            res.event_code = cct_pkg::EV_SRC_EPOCH;
        end else if (mdl_id_ok && r.link != mdl_link) begin
            latch_baseline(r);
            res.event_code = cct_pkg::EV_LINK_EPOCH;
        end else if (r.width == cct_pkg::WIDTH_BAD
                     || (r.width == cct_pkg::WIDTH_32 && r.value[63:32] != 0)) begin
            mdl_base_ok = 0;
            res.event_code = cct_pkg::EV_RANGE;
            res.ok = 0;
        end else if (mdl_base_ok && r.width != mdl_width) begin
            latch_baseline(r);
            res.event_code = cct_pkg::EV_WIDTH_CHG;
        end else if (mdl_base_ok && r.seq < mdl_seq) begin
            res.event_code = cct_pkg::EV_SEQ_REGR;
        end else if (r.reset_flag) begin
            latch_baseline(r);
            res.event_code = cct_pkg::EV_RESET;
        end else if (!mdl_base_ok) begin
            latch_baseline(r);
            res.event_code = cct_pkg::EV_BASELINE;
        end else begin
            diff = r.stamp - mdl_stamp;
            if (r.seq - mdl_seq > 64'd1)
                mdl_missing = mdl_missing + (r.seq - mdl_seq - 64'd1);
            if (r.stamp[63] != mdl_stamp[63] && diff[63] != r.stamp[63])
                el = {1'b0, cct_pkg::ELAPSED_MAX};
            else if (diff[63])
                el = 64'd0;
            else
                el = diff;
            gap = (el[62:0] > mdl_max_gap) || (el == 64'd0);
            proven = 0;
            if (r.value < mdl_value && mdl_wrap_en && r.width != cct_pkg::WIDTH_NONE)
                proven = !(mdl_value < wrap_bound(r.width, mdl_ceil_frac) ||
                           r.value > wrap_bound(r.width, mdl_floor_frac));
            if (r.value >= mdl_value || proven) begin
                res.event_code = (r.value >= mdl_value) ? cct_pkg::EV_ADVANCE
                                                        : cct_pkg::EV_WRAP;
                res.wrapped = proven;
                if (proven && r.width == cct_pkg::WIDTH_32)
                    res.delta = (64'h1_0000_0000 - mdl_value) + r.value;
                else
                    res.delta = r.value - mdl_value;
                res.elapsed = el[62:0];
                res.gap = gap;
                res.usable = !gap;
                if (gap && mdl_gaps != 32'hFFFF_FFFF)
                    mdl_gaps = mdl_gaps + 32'd1;
                latch_baseline(r);
            end else begin
                latch_baseline(r);
                res.event_code = cct_pkg::EV_UNPROVEN;
                res.ok = 0;
            end
        end
        res.missing = mdl_missing;
        res.gap_total = mdl_gaps;
        return res;
    endfunction

    // random idle burst with push low, in about one call of four; none when quiet
    task automatic maybe_idle();
        int n;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 11);
            push <= 0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // drive one reading and hold it until accepted
    task automatic send_reading(cct_pkg::t_item r, bit has_ev, logic [3:0] ev);
        cct_pkg::t_result res;
        res = classify_reading(r);
        if (has_ev && res.event_code != ev) begin
            $error("event_code table: expected %0d actual %0d", ev, res.event_code);
            errors++;
        end
        if (res.event_code == cct_pkg::EV_WRAP)
            n_wraps++;
        expected_results.push_back(res);
        i_reading_value <= r.value;
        i_width_code <= r.width;
        i_reset_flag <= r.reset_flag;
        i_stamp_nanos <= r.stamp;
        i_seq_number <= r.seq;
        i_source_epoch <= r.src;
        i_link_epoch <= r.link;
        push <= 1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        n_pushed++;
        @(negedge i_clk);
        maybe_idle();
    endtask

    // one write strobe, then write enable held low before the task returns
    task automatic write_reg(logic [1:0] idx, logic [62:0] data);
        i_cfg_wen <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_wen <= 0;
        case (idx)
            cct_pkg::REG_WRAP_EN: mdl_wrap_en = data[0];
            cct_pkg::REG_CEILING: mdl_ceil_frac = data[16:0];
            cct_pkg::REG_FLOOR:   mdl_floor_frac = data[16:0];
            default:              mdl_max_gap = data;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        push <= 0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // result side: pop with random stalls, compare against oldest expectation
    always @(posedge i_clk) begin
        cct_pkg::t_result e;
        if (i_rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                e = expected_results.pop_front();
                n_checked++;
                if (o_event_code !== e.event_code) begin
                    $error("event_code expected %0d actual %0d", e.event_code, o_event_code);
                    errors++;
                end
                if (o_continuity_ok !== e.ok) begin
                    $error("continuity_ok expected %0d actual %0d", e.ok, o_continuity_ok);
                    errors++;
                end
                if (o_value_delta !== e.delta) begin
                    $error("value_delta expected %0h actual %0h", e.delta, o_value_delta);
                    errors++;
                end
                if (o_elapsed_time !== e.elapsed) begin
                    $error("elapsed_time expected %0h actual %0h", e.elapsed, o_elapsed_time);
                    errors++;
                end
                if (o_gap_flag !== e.gap) begin
                    $error("gap_flag expected %0d actual %0d", e.gap, o_gap_flag);
                    errors++;
                end
                if (o_wrap_flag !== e.wrapped) begin
                    $error("wrap_flag expected %0d actual %0d", e.wrapped, o_wrap_flag);
                    errors++;
                end
                if (o_rate_usable !== e.usable) begin
                    $error("rate_usable expected %0d actual %0d", e.usable, o_rate_usable);
                    errors++;
                end
                if (o_missing_total !== e.missing) begin
                    $error("missing_total expected %0h actual %0h", e.missing, o_missing_total);
                    errors++;
                end
                if (o_gap_total !== e.gap_total) begin
                    $error("gap_total expected %0d actual %0d", e.gap_total, o_gap_total);
                    errors++;
                end
            end
        end
    end

    // pop stalls in bursts
    initial begin
        int n;
        pop = 0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 4) == 0) begin
                pop <= 0;
                n = $urandom_range(1, 11);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                pop <= 1;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random reading, mostly a plausible follow-on of the last one
    function automatic cct_pkg::t_item next_reading(cct_pkg::t_item prev);
        cct_pkg::t_item r;
        int k;
        r = prev;
        r.reset_flag = ($urandom_range(0, 29) == 0);
        k = $urandom_range(0, 99);
        if (k < 3) r.src = $urandom();
        else if (k < 6) r.link = $urandom();
        else if (k < 9) r.width = 2'($urandom_range(0, 3));
        if (r.width == cct_pkg::WIDTH_BAD && $urandom_range(0, 1)) r.width = WIDTH_64;
        // sequence: mostly +1, sometimes skip, regress or jump to a random value
        k = $urandom_range(0, 19);
        if (k == 0) r.seq = rand64();
        else if (k < 3) r.seq = prev.seq - 64'($urandom_range(1, 3));
        else if (k < 6) r.seq = prev.seq + 64'($urandom_range(2, 100));
        else r.seq = prev.seq + 64'd1;
        // timestamp: small steps, sometimes huge, equal or backwards
        k = $urandom_range(0, 19);
        if (k == 0) r.stamp = rand64();
        else if (k == 1) r.stamp = prev.stamp - 64'($urandom_range(0, 1000));
        else if (k == 2) r.stamp = prev.stamp;
        else if (k == 3) r.stamp = prev.stamp + {$urandom_range(0, 40), $urandom()};
        else r.stamp = prev.stamp + 64'($urandom_range(1, 2000000000));
        // value: advance, near the top, wrap-like drop, or anything
        k = $urandom_range(0, 19);
        if (k < 2) r.value = rand64();
        else if (k < 6) begin
            if (r.width == cct_pkg::WIDTH_32)
                r.value = 64'($urandom_range(0, 32'h1000_0000));
            else r.value = {$urandom_range(0, 32'h1000_0000), $urandom()};
        end else if (k < 9) begin
            if (r.width == cct_pkg::WIDTH_32)
                r.value = 64'hFFFF_0000 + 64'($urandom_range(0, 16'hFFFF));
            else r.value = {32'hFFFF_FFF0 | $urandom_range(0, 15), $urandom()};
        end else r.value = prev.value + 64'($urandom_range(0, 100000));
        if (r.width == cct_pkg::WIDTH_32 && $urandom_range(0, 9) != 0) r.value[63:32] = 0;
        return r;
    endfunction

    initial begin
        t_row rows[$];
        t_row row;
        cct_pkg::t_item r;
        cct_pkg::t_item last;
        int phase;
        push = 0;
        i_rst_n = 0;
        i_reading_value = 0;
        i_width_code = 0;
        i_reset_flag = 0;
        i_stamp_nanos = 0;
        i_seq_number = 0;
        i_source_epoch = 0;
        i_link_epoch = 0;
        i_cfg_wen = 0;
        i_cfg_index = cct_pkg::REG_WRAP_EN;
        i_cfg_data = 0;
        mdl_wrap_en = 1;
        mdl_ceil_frac = 17'd58982;
        mdl_floor_frac = 17'd6554;
        mdl_max_gap = 63'd60000000000;
        mdl_base_ok = 0;
        mdl_id_ok = 0;
        mdl_value = 0;
        mdl_width = 0;
        mdl_seq = 0;
        mdl_stamp = 0;
        mdl_src = 0;
        mdl_link = 0;
        mdl_missing = 0;
        mdl_gaps = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1;

        // directed table: {value, width, reset, stamp, seq, src, link}, event
        rows.push_back('{'{64'hFFFF_FFF0, cct_pkg::WIDTH_32, 0, 64'd100, 64'd1, 0, 0},
                         1, cct_pkg::EV_BASELINE});
        rows.push_back('{'{64'h10, cct_pkg::WIDTH_32, 0, 64'd200, 64'd2, 0, 0},
                         1, cct_pkg::EV_WRAP});
        rows.push_back('{'{64'h1_0000_0000, cct_pkg::WIDTH_32, 0, 64'd300, 64'd3, 0, 0},
                         1, cct_pkg::EV_RANGE});
        rows.push_back('{'{64'hFFFF_FFFF, cct_pkg::WIDTH_32, 0, 64'd300, 64'd3, 0, 0},
                         1, cct_pkg::EV_BASELINE});
        rows.push_back('{'{64'hFFFF_FFFF, cct_pkg::WIDTH_32, 0, 64'd300, 64'd9, 0, 0},
                         1, cct_pkg::EV_ADVANCE});
        rows.push_back('{'{64'h8000_0000, cct_pkg::WIDTH_32, 0, 64'd400, 64'd10, 0, 0},
                         1, cct_pkg::EV_UNPROVEN});
        rows.push_back('{'{64'h9000_0000, cct_pkg::WIDTH_32, 0, 64'd500, 64'd4, 0, 0},
                         1, cct_pkg::EV_SEQ_REGR});
        rows.push_back('{'{64'd5, cct_pkg::WIDTH_BAD, 0, 64'd500, 64'd11, 0, 0},
                         1, cct_pkg::EV_RANGE});
        rows.push_back('{'{64'hFFFF_FFFF_FFFF_FFFF, WIDTH_64, 0,
                          64'h8000_0000_0000_0000, 64'd0, 0, 0}, 1, cct_pkg::EV_BASELINE});
        rows.push_back('{'{64'd0, WIDTH_64, 0, 64'h7FFF_FFFF_FFFF_FFFF,
                          64'hFFFF_FFFF_FFFF_FFFF, 0, 0}, 1, cct_pkg::EV_WRAP});
        rows.push_back('{'{64'd7, cct_pkg::WIDTH_32, 0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0},
                         1, cct_pkg::EV_WIDTH_CHG});
        rows.push_back('{'{64'd3, cct_pkg::WIDTH_32, 1, 64'd10, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0},
                         1, cct_pkg::EV_RESET});
        rows.push_back('{'{64'd1, cct_pkg::WIDTH_NONE, 0, 64'd5, 64'd0, 32'hFFFF_FFFF, 0},
                         1, cct_pkg::EV_SRC_EPOCH});
        rows.push_back('{'{64'd0, cct_pkg::WIDTH_NONE, 0, 64'd6, 64'd1,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1, cct_pkg::EV_LINK_EPOCH});
        rows.push_back('{'{64'd9, cct_pkg::WIDTH_NONE, 0, 64'd6, 64'd2,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1, cct_pkg::EV_ADVANCE});
        rows.push_back('{'{64'd2, cct_pkg::WIDTH_NONE, 0, 64'd7, 64'd3,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1, cct_pkg::EV_UNPROVEN});
        rows.push_back('{'{64'd8, cct_pkg::WIDTH_NONE, 0, 64'hFFFF_FFFF_FFFF_0000, 64'd4,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0, cct_pkg::EV_ADVANCE});
        rows.push_back('{'{64'd9, cct_pkg::WIDTH_NONE, 0, 64'd70000000000, 64'd5,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0, cct_pkg::EV_ADVANCE});
        foreach (rows[i]) begin
            row = rows[i];
            send_reading(row.rd, row.has_ev, row.ev);
        end
        last = rows[rows.size() - 1].rd;
        drain();

        // random phases, each with its own register setting; extremes first
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(cct_pkg::REG_WRAP_EN, 63'd0);
                    write_reg(cct_pkg::REG_CEILING, 63'd0);
                    write_reg(cct_pkg::REG_FLOOR, 63'h10000);
                    write_reg(cct_pkg::REG_MAX_GAP, 63'd0);
                end
                1: begin
                    write_reg(cct_pkg::REG_WRAP_EN, 63'd1);
                    write_reg(cct_pkg::REG_CEILING, 63'h1FFFF);
                    write_reg(cct_pkg::REG_FLOOR, 63'h1FFFF);
                    write_reg(cct_pkg::REG_MAX_GAP, {63{1'b1}});
                end
                2: begin
                    write_reg(cct_pkg::REG_CEILING, 63'd0);
                    write_reg(cct_pkg::REG_FLOOR, 63'h10000);
                    write_reg(cct_pkg::REG_MAX_GAP, 63'd1000000000);
                end
                default: begin
                    write_reg(cct_pkg::REG_WRAP_EN, 63'($urandom_range(0, 3) != 0));
                    write_reg(cct_pkg::REG_CEILING, 63'($urandom_range(0, 17'h1FFFF)));
                    write_reg(cct_pkg::REG_FLOOR, 63'($urandom_range(0, 17'h1FFFF)));
                    write_reg(cct_pkg::REG_MAX_GAP,
                              63'({$urandom_range(0, 15), $urandom()}));
                end
            endcase
            if (phase == 7) quiet = 1;
            repeat (N_RANDOM / 8) begin
                r = next_reading(last);
                send_reading(r, 0, cct_pkg::EV_BASELINE);
                last = r;
            end
            drain();
        end

        $display("covered %0d readings, %0d results checked, %0d wraps, 8 register settings",
                 n_pushed, n_checked, n_wraps);
        if (errors == 0)
            $display("[counter_continuity_tracker_top] OK");
        else
            $display("[counter_continuity_tracker_top] ERROR");
        $finish;
    end

endmodule
